>>> rtl/pvp_pkg.sv
// Package for the polyboard vertex pair pipeline.
// Holds the shared types, format constants, stage counts and register codes.
// No dependencies.
package pvp_pkg;

    typedef logic signed [31:0] pos_t;
    typedef logic signed [15:0] nrm_t;

    localparam int NFB        = 14;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = NFB + 1;
    localparam int NUM_W      = 31 + NFB;
    localparam int NORM_LAT   = 7 + SQRT_STEPS + DIV_STEPS + 2;
    localparam int OFF_LAT    = 8;
    localparam int PIPE_LAT   = NORM_LAT + OFF_LAT;

    typedef enum logic [1:0] {
        REG_CAM_X,
        REG_CAM_Y,
        REG_CAM_Z,
        REG_HALF_WIDTH
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][29:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } nside_t;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [31:0]      u;
    } pu_t;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][15:0] nrm;
        logic [31:0]      u;
        logic             degen;
    } opass_t;

endpackage

>>> rtl/pvp_norm.sv
// Pipelined vector normalizer: difference, scaling, square root and division.
// One item enters per enabled cycle. Depends on pvp_pkg.
module pvp_norm import pvp_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  pos_t a [3],
    input  pos_t b [3],
    output nrm_t n [3],
    output logic zero
);

    logic signed [32:0] d1_reg [3];
    logic [32:0]        m2_reg [3];
    logic [2:0]         neg2_reg;
    logic [32:0]        m3_reg [3];
    logic [32:0]        mx3_reg;
    logic [2:0]         neg3_reg;
    logic               zero3_reg;
    logic [32:0]        m4_reg [3];
    logic [1:0]         rs4_reg;
    logic [4:0]         ls4_reg;
    logic [2:0]         neg4_reg;
    logic               zero4_reg;
    nside_t             sd_reg [0:SQRT_STEPS+2];
    logic [59:0]        sq6_reg [3];
    logic [61:0]        x_reg [0:SQRT_STEPS];
    logic [62:0]        r_reg [0:SQRT_STEPS];
    logic [61:0]        x_next [SQRT_STEPS];
    logic [62:0]        r_next [SQRT_STEPS];
    logic [NUM_W-1:0]     rem_reg [0:DIV_STEPS][3];
    logic [DIV_STEPS-1:0] q_reg [0:DIV_STEPS][3];
    logic [30:0]          den_reg [0:DIV_STEPS];
    logic [2:0]           dneg_reg [0:DIV_STEPS];
    logic                 dzero_reg [0:DIV_STEPS];
    logic [NUM_W-1:0]     rem_next [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] q_next [DIV_STEPS][3];
    nrm_t                 n_reg [3];
    logic                 zero_reg;

    logic [32:0] mx_next;
    logic [5:0]  lead_next;
    logic [1:0]  rs_next;
    logic [4:0]  ls_next;
    logic [29:0] sm_next [3];
    logic [61:0] sh_tmp [3];
    logic [30:0] len;
    nrm_t        n_next [3];

    function automatic logic [5:0] lead_pos(input logic [32:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    function automatic nrm_t sat_nrm(input logic signed [DIV_STEPS:0] v);
        nrm_t r;
        if (v > 32767) begin
            r = 16'sh7fff;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    always_comb begin
        mx_next = m2_reg[0];
        if (m2_reg[1] > mx_next) begin
            mx_next = m2_reg[1];
        end
        if (m2_reg[2] > mx_next) begin
            mx_next = m2_reg[2];
        end
        lead_next = lead_pos(mx3_reg);
        rs_next   = '0;
        ls_next   = '0;
        if (lead_next >= 6'd30) begin
            rs_next = 2'(lead_next - 6'd29);
        end else if (lead_next < 6'd29) begin
            ls_next = 5'(6'd29 - lead_next);
        end
        for (int i = 0; i < 3; i++) begin
            sh_tmp[i]  = 62'(m4_reg[i] >> rs4_reg) << ls4_reg;
            sm_next[i] = sh_tmp[i][29:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]   <= 33'(a[i]) - 33'(b[i]);
                m2_reg[i]   <= d1_reg[i][32] ? 33'(-d1_reg[i]) : 33'(d1_reg[i]);
                neg2_reg[i] <= d1_reg[i][32];
                m3_reg[i]   <= m2_reg[i];
                m4_reg[i]   <= m3_reg[i];
                sd_reg[0].mag[i] <= sm_next[i];
                sq6_reg[i]  <= 60'(sd_reg[0].mag[i]) * 60'(sd_reg[0].mag[i]);
            end
            mx3_reg   <= mx_next;
            neg3_reg  <= neg2_reg;
            zero3_reg <= (m2_reg[0] == '0) && (m2_reg[1] == '0) && (m2_reg[2] == '0);
            rs4_reg   <= rs_next;
            ls4_reg   <= ls_next;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            sd_reg[0].neg  <= neg4_reg;
            sd_reg[0].zero <= zero4_reg;
            sd_reg[1] <= sd_reg[0];
            sd_reg[2] <= sd_reg[1];
            x_reg[0]  <= 62'(sq6_reg[0]) + 62'(sq6_reg[1]) + 62'(sq6_reg[2]);
            r_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [62:0] BIT = 63'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [62:0] trial;

        always_comb begin
            trial = r_reg[k] + BIT;
            if ({1'b0, x_reg[k]} >= trial) begin
                x_next[k] = 62'({1'b0, x_reg[k]} - trial);
                r_next[k] = (r_reg[k] >> 1) + BIT;
            end else begin
                x_next[k] = x_reg[k];
                r_next[k] = r_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k+1]  <= x_next[k];
                r_reg[k+1]  <= r_next[k];
                sd_reg[k+3] <= sd_reg[k+2];
            end
        end
    end

    assign len = r_reg[SQRT_STEPS][30:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= (NUM_W'(sd_reg[SQRT_STEPS+2].mag[i]) << NFB)
                               + NUM_W'(len >> 1);
                q_reg[0][i]   <= '0;
            end
            den_reg[0]   <= len;
            dneg_reg[0]  <= sd_reg[SQRT_STEPS+2].neg;
            dzero_reg[0] <= sd_reg[SQRT_STEPS+2].zero;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [NUM_W:0] dsh;

        always_comb begin
            dsh = (NUM_W + 1)'(den_reg[k]) << SH;
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, rem_reg[k][i]} >= dsh) begin
                    rem_next[k][i] = NUM_W'({1'b0, rem_reg[k][i]} - dsh);
                    q_next[k][i]   = {q_reg[k][i][DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_next[k][i] = rem_reg[k][i];
                    q_next[k][i]   = {q_reg[k][i][DIV_STEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[k+1][i] <= rem_next[k][i];
                    q_reg[k+1][i]   <= q_next[k][i];
                end
                den_reg[k+1]   <= den_reg[k];
                dneg_reg[k+1]  <= dneg_reg[k];
                dzero_reg[k+1] <= dzero_reg[k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dzero_reg[DIV_STEPS]) begin
                n_next[i] = '0;
            end else if (dneg_reg[DIV_STEPS][i]) begin
                n_next[i] = sat_nrm(-$signed({1'b0, q_reg[DIV_STEPS][i]}));
            end else begin
                n_next[i] = sat_nrm($signed({1'b0, q_reg[DIV_STEPS][i]}));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= n_next[i];
            end
            zero_reg <= dzero_reg[DIV_STEPS];
        end
    end

    assign n    = n_reg;
    assign zero = zero_reg;

endmodule

>>> rtl/pvp_offset.sv
// Offset pipeline: cross product, width scaling, rounding and saturated vertex sums.
// Carries the position, normal, u and degenerate flag alongside. Depends on pvp_pkg.
module pvp_offset import pvp_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [30:0] half_width,
    input  nrm_t        t [3],
    input  nrm_t        z [3],
    input  opass_t      pass_in,
    output pos_t        g [3],
    output pos_t        h [3],
    output opass_t      pass_out
);

    localparam int CRW  = 35 - NFB;
    localparam int PW   = CRW + 32;
    localparam int DW   = PW + 2 - NFB;
    localparam int SW   = DW + 1;
    localparam logic [33:0] HALF_C = 34'(1) << (NFB - 1);
    localparam logic [PW:0] HALF_P = (PW + 1)'(1) << (NFB - 1);
    localparam logic signed [SW-1:0] SMAX = SW'(32'sh7fffffff);
    localparam logic signed [SW-1:0] SMIN = SW'(32'sh80000000);

    logic signed [31:0]     pa_reg [3];
    logic signed [31:0]     pb_reg [3];
    logic signed [32:0]     c_reg [3];
    logic [33:0]            ra_reg [3];
    logic [2:0]             rn_reg;
    logic signed [CRW-1:0]  cr_reg [3];
    logic signed [PW-1:0]   pd_reg [3];
    logic [PW:0]            pm_reg [3];
    logic [2:0]             pn_reg;
    logic signed [DW-1:0]   d_reg [3];
    opass_t                 pass_reg [0:OFF_LAT-2];
    pos_t                   g_reg [3];
    pos_t                   h_reg [3];
    opass_t                 out_reg;

    logic signed [CRW-1:0] cr_next [3];
    logic signed [DW-1:0]  d_next [3];
    logic signed [SW-1:0]  gs [3];
    logic signed [SW-1:0]  hs [3];

    function automatic pos_t sat_pos(input logic signed [SW-1:0] v);
        pos_t r;
        if (v > SMAX) begin
            r = 32'sh7fffffff;
        end else if (v < SMIN) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr_next[i] = CRW'($signed({1'b0, ra_reg[i] >> NFB}));
            if (rn_reg[i]) begin
                cr_next[i] = -cr_next[i];
            end
            d_next[i] = DW'($signed({1'b0, pm_reg[i] >> NFB}));
            if (pn_reg[i]) begin
                d_next[i] = -d_next[i];
            end
            gs[i] = SW'($signed(pass_reg[OFF_LAT-2].p[i])) + SW'(d_reg[i]);
            hs[i] = SW'($signed(pass_reg[OFF_LAT-2].p[i])) - SW'(d_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg[0] <= 32'(t[1]) * 32'(z[2]);
            pb_reg[0] <= 32'(t[2]) * 32'(z[1]);
            pa_reg[1] <= 32'(t[2]) * 32'(z[0]);
            pb_reg[1] <= 32'(t[0]) * 32'(z[2]);
            pa_reg[2] <= 32'(t[0]) * 32'(z[1]);
            pb_reg[2] <= 32'(t[1]) * 32'(z[0]);
            for (int i = 0; i < 3; i++) begin
                c_reg[i]  <= 33'(pa_reg[i]) - 33'(pb_reg[i]);
                ra_reg[i] <= {1'b0, (c_reg[i][32] ? 33'(-c_reg[i]) : 33'(c_reg[i]))}
                           + HALF_C;
                rn_reg[i] <= c_reg[i][32];
                cr_reg[i] <= cr_next[i];
                pd_reg[i] <= PW'(cr_reg[i]) * PW'($signed({1'b0, half_width}));
                pm_reg[i] <= {1'b0, (pd_reg[i][PW-1] ? PW'(-pd_reg[i]) : PW'(pd_reg[i]))}
                           + HALF_P;
                pn_reg[i] <= pd_reg[i][PW-1];
                d_reg[i]  <= d_next[i];
                g_reg[i]  <= sat_pos(gs[i]);
                h_reg[i]  <= sat_pos(hs[i]);
            end
            pass_reg[0] <= pass_in;
            for (int k = 1; k < OFF_LAT - 1; k++) begin
                pass_reg[k] <= pass_reg[k-1];
            end
            out_reg <= pass_reg[OFF_LAT-2];
        end
    end

    assign g        = g_reg;
    assign h        = h_reg;
    assign pass_out = out_reg;

endmodule

>>> rtl/polyboard_vertex_pair.sv
// Polyboard vertex pair expansion: one G/H vertex pair per input point.
// Throughput is one item per cycle while the output is not stalled.
// The depth comes from the 31 square-root steps and the 15 divider steps of
// the normalizers, followed by the offset pipeline. A stalled output holds the
// whole pipeline. Reset clears the valid bits and loads the register defaults.
module polyboard_vertex_pair import pvp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  pos_t        s_cur_x,
    input  pos_t        s_cur_y,
    input  pos_t        s_cur_z,
    input  pos_t        s_prev_x,
    input  pos_t        s_prev_y,
    input  pos_t        s_prev_z,
    input  pos_t        s_next_x,
    input  pos_t        s_next_y,
    input  pos_t        s_next_z,
    input  pos_t        s_tile_u,
    output logic        m_valid,
    input  logic        m_ready,
    output pos_t        m_g_x,
    output pos_t        m_g_y,
    output pos_t        m_g_z,
    output pos_t        m_h_x,
    output pos_t        m_h_y,
    output pos_t        m_h_z,
    output nrm_t        m_normal_x,
    output nrm_t        m_normal_y,
    output nrm_t        m_normal_z,
    output pos_t        m_u_out,
    output logic        m_degenerate
);

    pos_t          cam_reg [3];
    logic [30:0]   half_width_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    pu_t           pu_reg [0:NORM_LAT-1];
    logic          en;

    pos_t   cur_v [3];
    pos_t   prev_v [3];
    pos_t   next_v [3];
    nrm_t   zn [3];
    nrm_t   tn [3];
    logic   z_zero;
    logic   t_zero;
    opass_t pass_in;
    opass_t pass_out;
    pos_t   g [3];
    pos_t   h [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg[0]     <= '0;
            cam_reg[1]     <= '0;
            cam_reg[2]     <= '0;
            half_width_reg <= 31'd65536;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_CAM_X:      cam_reg[0] <= cfg_data;
                REG_CAM_Y:      cam_reg[1] <= cfg_data;
                REG_CAM_Z:      cam_reg[2] <= cfg_data;
                REG_HALF_WIDTH: half_width_reg <= cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid = vld_reg[PIPE_LAT-1];
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    assign cur_v[0]  = s_cur_x;
    assign cur_v[1]  = s_cur_y;
    assign cur_v[2]  = s_cur_z;
    assign prev_v[0] = s_prev_x;
    assign prev_v[1] = s_prev_y;
    assign prev_v[2] = s_prev_z;
    assign next_v[0] = s_next_x;
    assign next_v[1] = s_next_y;
    assign next_v[2] = s_next_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            pu_reg[0].p[0] <= s_cur_x;
            pu_reg[0].p[1] <= s_cur_y;
            pu_reg[0].p[2] <= s_cur_z;
            pu_reg[0].u    <= s_tile_u;
            for (int k = 1; k < NORM_LAT; k++) begin
                pu_reg[k] <= pu_reg[k-1];
            end
        end
    end

    pvp_norm u_norm_view (
        .aclk (aclk),
        .en   (en),
        .a    (cam_reg),
        .b    (cur_v),
        .n    (zn),
        .zero (z_zero)
    );

    pvp_norm u_norm_tan (
        .aclk (aclk),
        .en   (en),
        .a    (next_v),
        .b    (prev_v),
        .n    (tn),
        .zero (t_zero)
    );

    always_comb begin
        pass_in.p     = pu_reg[NORM_LAT-1].p;
        pass_in.u     = pu_reg[NORM_LAT-1].u;
        pass_in.degen = z_zero || t_zero;
        for (int i = 0; i < 3; i++) begin
            pass_in.nrm[i] = zn[i];
        end
    end

    pvp_offset u_offset (
        .aclk       (aclk),
        .en         (en),
        .half_width (half_width_reg),
        .t          (tn),
        .z          (zn),
        .pass_in    (pass_in),
        .g          (g),
        .h          (h),
        .pass_out   (pass_out)
    );

    assign m_g_x        = g[0];
    assign m_g_y        = g[1];
    assign m_g_z        = g[2];
    assign m_h_x        = h[0];
    assign m_h_y        = h[1];
    assign m_h_z        = h[2];
    assign m_normal_x   = pass_out.nrm[0];
    assign m_normal_y   = pass_out.nrm[1];
    assign m_normal_z   = pass_out.nrm[2];
    assign m_u_out      = pass_out.u;
    assign m_degenerate = pass_out.degen;

endmodule
